### src/bms_pkg.sv
// ----------------------------------------------------------------------------
// bms_pkg: shared types, codes and note ROM for the buzzer melody sequencer
// The melody table gives the offset and length of each melody in the note ROM.
// Each ROM entry holds one note as a frequency and a duration.
// ----------------------------------------------------------------------------
package bms_pkg;

   // Note ROM geometry. The address covers the largest melody offset plus a
   // 3-bit note index.
   localparam int NOTE_ROM_DEPTH = 32;
   localparam int ROM_ADDR_W     = 5;
   localparam int FREQ_W         = 12;
   localparam int DUR_W          = 11;
   localparam int TIME_W         = 32;

   // Melody ids
   localparam logic [2:0] MEL_LOCK     = 3'd0;
   localparam logic [2:0] MEL_LOST     = 3'd1;
   localparam logic [2:0] MEL_FLIGHT   = 3'd2;
   localparam logic [2:0] MEL_GROUND   = 3'd3;
   localparam logic [2:0] MEL_DEBUG    = 3'd4;
   localparam logic [2:0] MEL_RECOVERY = 3'd5;

   // System mode codes
   localparam logic [1:0] MODE_FLIGHT = 2'd0;
   localparam logic [1:0] MODE_GROUND = 2'd1;
   localparam logic [1:0] MODE_DEBUG  = 2'd2;
   localparam logic [1:0] MODE_OTHER  = 2'd3;

   // System state codes
   localparam logic [1:0] ST_SEARCH   = 2'd0;
   localparam logic [1:0] ST_LOCK     = 2'd1;
   localparam logic [1:0] ST_RECOVERY = 2'd2;
   localparam logic [1:0] ST_OTHER    = 2'd3;

   typedef struct packed {
      logic [2:0]        melody_id;
      logic [2:0]        note_index;
      logic [TIME_W-1:0] note_start_ms;
      logic              playing;
   } play_state_type;

   typedef struct packed {
      logic [FREQ_W-1:0] freq;
      logic [DUR_W-1:0]  dur;
   } note_type;

   function automatic logic [ROM_ADDR_W-1:0] mel_off(input logic [2:0] id);
      logic [ROM_ADDR_W-1:0] off;
      case (id)
         MEL_LOCK:     off = 5'd0;
         MEL_LOST:     off = 5'd3;
         MEL_FLIGHT:   off = 5'd6;
         MEL_GROUND:   off = 5'd11;
         MEL_DEBUG:    off = 5'd14;
         MEL_RECOVERY: off = 5'd18;
         default:      off = 5'd0;
      endcase
      return off;
   endfunction

   function automatic logic [2:0] mel_len(input logic [2:0] id);
      logic [2:0] len;
      case (id)
         MEL_LOCK:     len = 3'd3;
         MEL_LOST:     len = 3'd3;
         MEL_FLIGHT:   len = 3'd5;
         MEL_GROUND:   len = 3'd3;
         MEL_DEBUG:    len = 3'd4;
         MEL_RECOVERY: len = 3'd2;
         default:      len = 3'd0;
      endcase
      return len;
   endfunction

   // Note ROM; entries past the table and past the ROM depth read as zero.
   function automatic note_type rom_note(input logic [ROM_ADDR_W-1:0] addr);
      note_type n;
      n = '0;
      if (int'(addr) < NOTE_ROM_DEPTH) begin
         case (addr)
            5'd0:    n = '{freq: 12'd880,  dur: 11'd120};
            5'd1:    n = '{freq: 12'd0,    dur: 11'd60};
            5'd2:    n = '{freq: 12'd1175, dur: 11'd220};
            5'd3:    n = '{freq: 12'd1175, dur: 11'd220};
            5'd4:    n = '{freq: 12'd0,    dur: 11'd80};
            5'd5:    n = '{freq: 12'd700,  dur: 11'd300};
            5'd6:    n = '{freq: 12'd523,  dur: 11'd90};
            5'd7:    n = '{freq: 12'd784,  dur: 11'd90};
            5'd8:    n = '{freq: 12'd1047, dur: 11'd90};
            5'd9:    n = '{freq: 12'd1319, dur: 11'd150};
            5'd10:   n = '{freq: 12'd784,  dur: 11'd220};
            5'd11:   n = '{freq: 12'd1047, dur: 11'd120};
            5'd12:   n = '{freq: 12'd784,  dur: 11'd120};
            5'd13:   n = '{freq: 12'd1047, dur: 11'd200};
            5'd14:   n = '{freq: 12'd523,  dur: 11'd200};
            5'd15:   n = '{freq: 12'd0,    dur: 11'd200};
            5'd16:   n = '{freq: 12'd523,  dur: 11'd200};
            5'd17:   n = '{freq: 12'd0,    dur: 11'd200};
            5'd18:   n = '{freq: 12'd2200, dur: 11'd300};
            5'd19:   n = '{freq: 12'd0,    dur: 11'd1700};
            default: n = '0;
         endcase
      end
      return n;
   endfunction

   function automatic note_type melody_note(input logic [2:0] id, input logic [2:0] idx);
      return rom_note(mel_off(id) + {2'b00, idx});
   endfunction

endpackage

### src/buzzer_melody_sequencer.sv
// ----------------------------------------------------------------------------
// buzzer_melody_sequencer: tone melody sequencer for a status buzzer
// Plays short melodies from a fixed note ROM, one update beat in, one tone
// command beat out.
// ----------------------------------------------------------------------------
// Each request beat is one update tick and yields exactly one response beat.
// The block takes one beat per clock cycle when the response side keeps up
// and stalls the request side while reset is high. The state memory is read
// at the acceptance edge; the update runs in the following cycle and lands
// in the output register once that register is free or being drained, so
// a response stall holds the beat in the update stage until then. The
// playback state (melody, note index, note start time, playing flag) lives
// in a single-entry synchronous memory that is read at acceptance and
// written back when the beat moves to the output register; the value written
// on the same edge as a read is forwarded to the next beat. A mode change
// stops the tone and starts that mode's startup melody (none for mode
// other). Entering GPS lock plays the lock melody, dropping from lock back to
// searching plays the lost melody, and in recovery the recovery melody
// restarts whenever nothing plays. Notes advance when (now_ms - note start)
// modulo 2^32 reaches the note's duration. tone_freq and tone_len are zero
// unless tone_start is set. After reset the state reads as idle; send
// mode_changed on the first beat so the startup melody plays.
// ----------------------------------------------------------------------------
module buzzer_melody_sequencer (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_now_ms,
   input  logic        req_mode_changed,
   input  logic        req_state_changed,
   input  logic [1:0]  req_sys_mode,
   input  logic [1:0]  req_sys_state,
   input  logic [1:0]  req_prior_state,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_tone_start,
   output logic        rsp_tone_stop,
   output logic [11:0] rsp_tone_freq,
   output logic [10:0] rsp_tone_len,
   output logic        rsp_is_playing
);

   // ------------------------------------------------------------------
   // Handshake
   // ------------------------------------------------------------------
   logic s1_vld_ff, s1_vld_in;
   logic rsp_vld_ff, rsp_vld_in;
   logic s1_go;
   logic req_take;

   // The update stage moves on whenever the output register is free or
   // is being drained this cycle. Hold off requests during reset.
   assign s1_go     = s1_vld_ff && (!rsp_vld_ff || !rsp_stall);
   assign req_stall = reset || (s1_vld_ff && !s1_go);
   assign req_take  = req_valid && !req_stall;

   assign s1_vld_in  = req_take || (s1_vld_ff && !s1_go);
   assign rsp_vld_in = s1_go || (rsp_vld_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff  <= s1_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   assign rsp_valid = rsp_vld_ff;

   // ------------------------------------------------------------------
   // Captured request beat
   // ------------------------------------------------------------------
   logic [31:0] now_ff;
   logic        mchg_ff;
   logic        schg_ff;
   logic [1:0]  mode_ff;
   logic [1:0]  st_ff;
   logic [1:0]  prev_ff;

   always_ff @(posedge clock) begin
      if (req_take) begin
         now_ff  <= req_now_ms;
         mchg_ff <= req_mode_changed;
         schg_ff <= req_state_changed;
         mode_ff <= req_sys_mode;
         st_ff   <= req_sys_state;
         prev_ff <= req_prior_state;
      end
   end

   // ------------------------------------------------------------------
   // Playback state memory, one entry, registered read
   // ------------------------------------------------------------------
   bms_pkg::play_state_type state_mem [0:0];
   bms_pkg::play_state_type rd_data_ff;
   bms_pkg::play_state_type wb_data_ff;
   bms_pkg::play_state_type cur_state;
   bms_pkg::play_state_type wr_state_in;
   logic                    mem_vld_ff;
   logic                    rd_vld_ff;
   logic                    fwd_ff;

   // Write back the updated state as the beat leaves the update stage.
   always_ff @(posedge clock) begin
      if (s1_go) begin
         state_mem[0] <= wr_state_in;
      end
   end

   // Read on acceptance; the read sees the old entry if a write lands on
   // the same edge, so flag that case for forwarding.
   always_ff @(posedge clock) begin
      if (req_take) begin
         rd_data_ff <= state_mem[0];
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go) begin
         wb_data_ff <= wr_state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mem_vld_ff <= 1'b0;
         rd_vld_ff  <= 1'b0;
         fwd_ff     <= 1'b0;
      end else begin
         if (s1_go) begin
            mem_vld_ff <= 1'b1;
         end
         if (req_take) begin
            rd_vld_ff <= mem_vld_ff;
            fwd_ff    <= s1_go;
         end
      end
   end

   // An entry never written reads as the idle reset state.
   always_comb begin
      if (fwd_ff) begin
         cur_state = wb_data_ff;
      end else if (rd_vld_ff) begin
         cur_state = rd_data_ff;
      end else begin
         cur_state = '0;
      end
   end

   // ------------------------------------------------------------------
   // Update
   // ------------------------------------------------------------------
   logic                 begin_en;
   logic [2:0]           begin_id;
   bms_pkg::note_type    begin_note;
   bms_pkg::note_type    cur_note;
   bms_pkg::note_type    next_note;
   logic [31:0]          elapsed;
   logic                 note_done;
   logic [2:0]           next_idx;
   logic                 tone_start;
   logic                 tone_stop;
   logic [11:0]          tone_freq;
   logic [10:0]          tone_len;

   // Pick the melody to start, if any. Every melody's first note has a
   // nonzero duration, so a melody started here never advances in the
   // same beat.
   always_comb begin
      begin_en = 1'b0;
      begin_id = bms_pkg::MEL_LOCK;
      if (mchg_ff) begin
         begin_en = (mode_ff != bms_pkg::MODE_OTHER);
         case (mode_ff)
            bms_pkg::MODE_FLIGHT: begin_id = bms_pkg::MEL_FLIGHT;
            bms_pkg::MODE_GROUND: begin_id = bms_pkg::MEL_GROUND;
            bms_pkg::MODE_DEBUG:  begin_id = bms_pkg::MEL_DEBUG;
            default:              begin_id = bms_pkg::MEL_LOCK;
         endcase
      end else if (schg_ff && st_ff == bms_pkg::ST_SEARCH
                   && prev_ff == bms_pkg::ST_LOCK) begin
         begin_en = 1'b1;
         begin_id = bms_pkg::MEL_LOST;
      end else if (schg_ff && st_ff == bms_pkg::ST_LOCK) begin
         begin_en = 1'b1;
         begin_id = bms_pkg::MEL_LOCK;
      end else if (st_ff == bms_pkg::ST_RECOVERY && !cur_state.playing) begin
         begin_en = 1'b1;
         begin_id = bms_pkg::MEL_RECOVERY;
      end
   end

   assign begin_note = bms_pkg::melody_note(begin_id, 3'd0);
   assign cur_note   = bms_pkg::melody_note(cur_state.melody_id, cur_state.note_index);
   assign next_idx   = cur_state.note_index + 3'd1;
   assign next_note  = bms_pkg::melody_note(cur_state.melody_id, next_idx);
   assign elapsed    = now_ff - cur_state.note_start_ms;
   assign note_done  = cur_state.playing && (elapsed >= {21'd0, cur_note.dur});

   always_comb begin
      wr_state_in = cur_state;
      tone_start  = 1'b0;
      tone_stop   = 1'b0;
      tone_freq   = '0;
      tone_len    = '0;
      if (mchg_ff) begin
         // Stop whatever plays, then start the mode's startup melody, if any.
         tone_stop   = 1'b1;
         wr_state_in = '0;
      end
      if (begin_en) begin
         wr_state_in.melody_id     = begin_id;
         wr_state_in.note_index    = 3'd0;
         wr_state_in.note_start_ms = now_ff;
         wr_state_in.playing       = 1'b1;
         tone_start                = 1'b1;
         tone_freq                 = begin_note.freq;
         tone_len                  = begin_note.dur;
      end else if (!mchg_ff && note_done) begin
         if (next_idx >= bms_pkg::mel_len(cur_state.melody_id)) begin
            // Past the last note: silence and drop back to idle.
            tone_stop   = 1'b1;
            wr_state_in = '0;
         end else begin
            wr_state_in.note_index    = next_idx;
            wr_state_in.note_start_ms = now_ff;
            tone_start                = 1'b1;
            tone_freq                 = next_note.freq;
            tone_len                  = next_note.dur;
         end
      end
   end

   // ------------------------------------------------------------------
   // Output register; holds while the response side stalls
   // ------------------------------------------------------------------
   logic        out_start_ff;
   logic        out_stop_ff;
   logic [11:0] out_freq_ff;
   logic [10:0] out_len_ff;
   logic        out_play_ff;

   always_ff @(posedge clock) begin
      if (s1_go) begin
         out_start_ff <= tone_start;
         out_stop_ff  <= tone_stop;
         out_freq_ff  <= tone_freq;
         out_len_ff   <= tone_len;
         out_play_ff  <= wr_state_in.playing;
      end
   end

   assign rsp_tone_start = out_start_ff;
   assign rsp_tone_stop  = out_stop_ff;
   assign rsp_tone_freq  = out_freq_ff;
   assign rsp_tone_len   = out_len_ff;
   assign rsp_is_playing = out_play_ff;

endmodule
